// ===== rtl/core/fce_pkg.sv =====
package fce_pkg;

   localparam int FRAC_BITS = 16;
   localparam int LOG_FB    = 24;
   localparam int POS_W     = 32;
   localparam int DIFF_W    = POS_W + 1;
   localparam int SIZE_W    = 20;
   localparam int WGT_W     = 16;
   localparam int WGT_FRAC  = 8;
   localparam int MD_W      = 31;
   localparam int COST_W    = 40;
   localparam int UTIL_W    = 32;
   localparam int CNT_W     = 16;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   localparam int MUL_W     = 33;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int SUM_W     = 64;
   localparam int ROOT_W    = 32;
   localparam int MANT_W    = 31;
   localparam int K_W       = 5;
   localparam int LG_W      = K_W + LOG_FB;
   localparam int IT_W      = $clog2(LOG_FB);
   localparam int LN_SHIFT  = 32 + LOG_FB - FRAC_BITS;
   localparam int LN_W      = FRAC_BITS + 6;
   localparam int ACC_W     = 43;
   localparam int DIV_W     = ((2 * FRAC_BITS > 39) ? 2 * FRAC_BITS : 39) + 1;
   localparam int TENTH     = ((1 << FRAC_BITS) + 5) / 10;

   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   localparam logic signed [COST_W-1:0] COST_MAX = 40'sh7F_FFFF_FFFF;
   localparam logic signed [COST_W-1:0] COST_MIN = 40'sh80_0000_0000;
   localparam logic signed [UTIL_W-1:0] UTIL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [UTIL_W-1:0] UTIL_MIN = 32'sh8000_0000;
   localparam logic [CNT_W-1:0]         CNT_MAX  = '1;

   localparam logic [WGT_W-1:0]         WD_RST = 16'd256;
   localparam logic [WGT_W-1:0]         WS_RST = 16'd128;
   localparam logic [WGT_W-1:0]         WH_RST = 16'd77;
   localparam logic signed [POS_W-1:0]  PH_RST = 32'sd131072;
   localparam logic [MD_W-1:0]          MD_RST = 31'd3276800;

   localparam logic CMD_POSE = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   typedef enum logic [2:0] {
      REG_WD,
      REG_WS,
      REG_WH,
      REG_PH,
      REG_MD
   } reg_idx_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ABS,
      S_RANGE,
      S_SQX,
      S_SQY,
      S_SQZ,
      S_SQM,
      S_ROOT,
      S_NORM,
      S_LOG,
      S_LN2,
      S_MULD,
      S_MULS,
      S_MULH,
      S_SAT,
      S_PREP,
      S_DABS,
      S_DIV,
      S_OUT
   } state_type;

   typedef struct packed {
      logic                    command;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [SIZE_W-1:0]       cluster_size;
      logic                    last_cluster;
   } req_type;

   typedef struct packed {
      logic                     reachable;
      logic signed [COST_W-1:0] cost;
      logic signed [UTIL_W-1:0] utility;
      logic [CNT_W-1:0]         reachable_total;
      logic                     table_end;
   } rsp_type;

endpackage

// ===== rtl/core/frontier_cost_evaluator.sv =====
// channel   direction  signals
// req       in         req_valid, req_stall, req_payload (pose update or cluster)
// rsp       out        rsp_valid, rsp_stall, rsp_payload (one result per scored cluster)
// csr       in         psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// a pose update or a cluster before any pose is absorbed in idle and gives no result
// a scored cluster offers its result after 32 passes on the bit-serial 33x33 multiplier
// (24 for the log squarings), the root and a divide unless the divisor is zero
// a component beyond the limit skips all of them, a sum beyond the squared limit all but the squares
// synchronous reset clears the weights to defaults, the pose and the count
// req_stall is high while a cluster is in work; a stalled result holds its
// slot and the next cluster waits in its output state
module frontier_cost_evaluator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  fce_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output fce_pkg::rsp_type              rsp_payload,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [fce_pkg::ADDR_W-1:0]    paddr,
   input  logic [fce_pkg::DATA_W-1:0]    pwdata,
   output logic [fce_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);
   import fce_pkg::*;

   state_type state_ff, state_in;
   logic      run_ff, run_in;

   logic [WGT_W-1:0]         wd_ff, wd_in, ws_ff, ws_in, wh_ff, wh_in;
   logic signed [POS_W-1:0]  ph_ff, ph_in;
   logic [MD_W-1:0]          md_ff, md_in;
   logic signed [POS_W-1:0]  px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic                     pose_ok_ff, pose_ok_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic [DIFF_W-1:0]        ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in, hz_ff, hz_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [ROOT_W-1:0]        dist_ff, dist_in;
   logic [MANT_W-1:0]        m_ff, m_in;
   logic [K_W-1:0]           k_ff, k_in;
   logic [LOG_FB-1:0]        frac_ff, frac_in;
   logic [IT_W-1:0]          it_ff, it_in;
   logic [LN_W-1:0]          ln_ff, ln_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [COST_W-1:0] cost_ff, cost_in;
   logic signed [COST_W:0]   div_ff, div_in;
   logic [DIV_W-1:0]         dmag_ff, dmag_in;
   logic signed [UTIL_W-1:0] util_ff, util_in;
   logic                     reach_ff, reach_in;
   logic                     last_ff, last_in;

   logic                     mul_start, mul_done, root_start, root_done, div_start, div_done;
   logic [MUL_W-1:0]         op_a, op_b;
   logic [PROD_W-1:0]        prod;
   logic [ROOT_W-1:0]        root;
   logic [DIV_W-1:0]         quo;
   logic [DIV_W-1:0]         numer;
   logic [MANT_W:0]          sq;
   logic [PROD_W-1:0]        ln_round;
   logic                     accept, csr_write;
   logic [CNT_W-1:0]         cnt_next;
   reg_idx_type              reg_idx;

   assign reg_idx   = reg_idx_type'(paddr[ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      case (reg_idx)
         REG_WD:  prdata = DATA_W'(wd_ff);
         REG_WS:  prdata = DATA_W'(ws_ff);
         REG_WH:  prdata = DATA_W'(wh_ff);
         REG_PH:  prdata = DATA_W'(ph_ff);
         REG_MD:  prdata = DATA_W'(md_ff);
         default: prdata = '0;
      endcase
   end

   always_comb begin
      case (state_ff)
         S_SQX:   begin op_a = ax_ff;             op_b = ax_ff;             end
         S_SQY:   begin op_a = ay_ff;             op_b = ay_ff;             end
         S_SQZ:   begin op_a = az_ff;             op_b = az_ff;             end
         S_SQM:   begin op_a = MUL_W'(md_ff);     op_b = MUL_W'(md_ff);     end
         S_LOG:   begin op_a = MUL_W'(m_ff);      op_b = MUL_W'(m_ff);      end
         S_LN2:   begin op_a = MUL_W'({k_ff, frac_ff}); op_b = MUL_W'(LN2_Q32); end
         S_MULD:  begin op_a = MUL_W'(wd_ff);     op_b = MUL_W'(dist_ff);   end
         S_MULS:  begin op_a = MUL_W'(ws_ff);     op_b = MUL_W'(ln_ff);     end
         S_MULH:  begin op_a = MUL_W'(wh_ff);     op_b = hz_ff;             end
         default: begin op_a = '0;                op_b = '0;                end
      endcase
   end

   fce_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (op_a),
      .op_b    (op_b),
      .done    (mul_done),
      .product (prod)
   );

   fce_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sum_ff),
      .done     (root_done),
      .root     (root)
   );

   assign numer = (DIV_W'(1) << (2 * FRAC_BITS)) + (dmag_ff >> 1);

   fce_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (numer),
      .divisor  (dmag_ff),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      state_in     = state_ff;
      run_in       = run_ff;
      wd_in = wd_ff; ws_in = ws_ff; wh_in = wh_ff; ph_in = ph_ff; md_in = md_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff;
      pose_ok_in   = pose_ok_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ax_in = ax_ff; ay_in = ay_ff; az_in = az_ff; hz_in = hz_ff;
      sum_in  = sum_ff;  dist_in = dist_ff; m_in = m_ff; k_in = k_ff;
      frac_in = frac_ff; it_in = it_ff; ln_in = ln_ff; acc_in = acc_ff;
      cost_in = cost_ff; div_in = div_ff; dmag_in = dmag_ff; util_in = util_ff;
      reach_in = reach_ff; last_in = last_ff;
      mul_start = 1'b0; root_start = 1'b0; div_start = 1'b0;
      sq       = prod[2*MANT_W-1:MANT_W-1];
      ln_round = prod + (PROD_W'(1) << (LN_SHIFT - 1));
      cnt_next = (reach_ff && cnt_ff != CNT_MAX) ? cnt_ff + 1'b1 : cnt_ff;

      if (csr_write) begin
         case (reg_idx)
            REG_WD:  wd_in = pwdata[WGT_W-1:0];
            REG_WS:  ws_in = pwdata[WGT_W-1:0];
            REG_WH:  wh_in = pwdata[WGT_W-1:0];
            REG_PH:  ph_in = $signed(pwdata[POS_W-1:0]);
            REG_MD:  md_in = pwdata[MD_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_payload.command == CMD_POSE) begin
                  px_in      = req_payload.pos_x;
                  py_in      = req_payload.pos_y;
                  pz_in      = req_payload.pos_z;
                  pose_ok_in = 1'b1;
               end else if (pose_ok_ff) begin
                  ax_in = DIFF_W'({req_payload.pos_x[POS_W-1], req_payload.pos_x}
                                - {px_ff[POS_W-1], px_ff});
                  ay_in = DIFF_W'({req_payload.pos_y[POS_W-1], req_payload.pos_y}
                                - {py_ff[POS_W-1], py_ff});
                  az_in = DIFF_W'({req_payload.pos_z[POS_W-1], req_payload.pos_z}
                                - {pz_ff[POS_W-1], pz_ff});
                  hz_in = DIFF_W'({req_payload.pos_z[POS_W-1], req_payload.pos_z}
                                - {ph_ff[POS_W-1], ph_ff});
                  m_in     = MANT_W'(req_payload.cluster_size) + 1'b1;
                  k_in     = K_W'(MANT_W - 1);
                  last_in  = req_payload.last_cluster;
                  state_in = S_ABS;
               end
            end
         end
         S_ABS: begin
            ax_in = ax_ff[DIFF_W-1] ? (~ax_ff + 1'b1) : ax_ff;
            ay_in = ay_ff[DIFF_W-1] ? (~ay_ff + 1'b1) : ay_ff;
            az_in = az_ff[DIFF_W-1] ? (~az_ff + 1'b1) : az_ff;
            hz_in = hz_ff[DIFF_W-1] ? (~hz_ff + 1'b1) : hz_ff;
            state_in = S_RANGE;
         end
         S_RANGE: begin
            if (ax_ff > DIFF_W'(md_ff) || ay_ff > DIFF_W'(md_ff) || az_ff > DIFF_W'(md_ff)) begin
               reach_in = 1'b0;
               state_in = S_OUT;
            end else begin
               state_in = S_SQX;
            end
         end
         S_SQX, S_SQY, S_SQZ, S_SQM, S_LOG, S_LN2, S_MULD, S_MULS, S_MULH: begin
            if (!run_ff) begin
               mul_start = 1'b1;
               run_in    = 1'b1;
            end else if (mul_done) begin
               run_in = 1'b0;
               case (state_ff)
                  S_SQX: begin
                     sum_in   = prod[SUM_W-1:0];
                     state_in = S_SQY;
                  end
                  S_SQY: begin
                     sum_in   = sum_ff + prod[SUM_W-1:0];
                     state_in = S_SQZ;
                  end
                  S_SQZ: begin
                     sum_in   = sum_ff + prod[SUM_W-1:0];
                     state_in = S_SQM;
                  end
                  S_SQM: begin
                     reach_in = (sum_ff <= prod[SUM_W-1:0]);
                     state_in = (sum_ff <= prod[SUM_W-1:0]) ? S_ROOT : S_OUT;
                  end
                  S_LOG: begin
                     m_in    = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
                     frac_in = {frac_ff[LOG_FB-2:0], sq[MANT_W]};
                     it_in   = it_ff + 1'b1;
                     if (it_ff == IT_W'(LOG_FB - 1)) begin
                        state_in = S_LN2;
                     end
                  end
                  S_LN2: begin
                     ln_in    = LN_W'(ln_round >> LN_SHIFT);
                     state_in = S_MULD;
                  end
                  S_MULD: begin
                     acc_in   = $signed(ACC_W'(prod >> WGT_FRAC));
                     state_in = S_MULS;
                  end
                  S_MULS: begin
                     acc_in   = acc_ff - $signed(ACC_W'(prod >> WGT_FRAC));
                     state_in = S_MULH;
                  end
                  S_MULH: begin
                     acc_in   = acc_ff + $signed(ACC_W'(prod >> WGT_FRAC));
                     state_in = S_SAT;
                  end
                  default: ;
               endcase
            end
         end
         S_ROOT: begin
            if (!run_ff) begin
               root_start = 1'b1;
               run_in     = 1'b1;
            end else if (root_done) begin
               run_in   = 1'b0;
               dist_in  = root;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (m_ff[MANT_W-1]) begin
               it_in    = '0;
               frac_in  = '0;
               state_in = S_LOG;
            end else begin
               m_in = {m_ff[MANT_W-2:0], 1'b0};
               k_in = k_ff - 1'b1;
            end
         end
         S_SAT: begin
            if (acc_ff > ACC_W'(COST_MAX)) begin
               cost_in = COST_MAX;
            end else if (acc_ff < ACC_W'(COST_MIN)) begin
               cost_in = COST_MIN;
            end else begin
               cost_in = COST_W'(acc_ff);
            end
            state_in = S_PREP;
         end
         S_PREP: begin
            div_in   = $signed({cost_ff[COST_W-1], cost_ff}) + (COST_W + 1)'(TENTH);
            state_in = S_DABS;
         end
         S_DABS: begin
            dmag_in = DIV_W'(div_ff[COST_W] ? (~div_ff + 1'b1) : div_ff);
            if (div_ff == '0) begin
               util_in  = UTIL_MAX;
               state_in = S_OUT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!run_ff) begin
               div_start = 1'b1;
               run_in    = 1'b1;
            end else if (div_done) begin
               run_in = 1'b0;
               if (!div_ff[COST_W]) begin
                  util_in = (quo > DIV_W'(UTIL_MAX)) ? UTIL_MAX : $signed(quo[UTIL_W-1:0]);
               end else begin
                  util_in = (quo > (DIV_W'(1) << (UTIL_W - 1))) ? UTIL_MIN
                          : $signed(-quo[UTIL_W-1:0]);
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_in.reachable       = reach_ff;
               rsp_in.cost            = reach_ff ? cost_ff : COST_MAX;
               rsp_in.utility         = reach_ff ? util_ff : '0;
               rsp_in.reachable_total = cnt_next;
               rsp_in.table_end       = last_ff;
               cnt_in                 = last_ff ? '0 : cnt_next;
               state_in               = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         run_ff       <= 1'b0;
         wd_ff        <= WD_RST;
         ws_ff        <= WS_RST;
         wh_ff        <= WH_RST;
         ph_ff        <= PH_RST;
         md_ff        <= MD_RST;
         px_ff        <= '0;
         py_ff        <= '0;
         pz_ff        <= '0;
         pose_ok_ff   <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         wd_ff        <= wd_in;
         ws_ff        <= ws_in;
         wh_ff        <= wh_in;
         ph_ff        <= ph_in;
         md_ff        <= md_in;
         px_ff        <= px_in;
         py_ff        <= py_in;
         pz_ff        <= pz_in;
         pose_ok_ff   <= pose_ok_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff   <= rsp_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      az_ff    <= az_in;
      hz_ff    <= hz_in;
      sum_ff   <= sum_in;
      dist_ff  <= dist_in;
      m_ff     <= m_in;
      k_ff     <= k_in;
      frac_ff  <= frac_in;
      it_ff    <= it_in;
      ln_ff    <= ln_in;
      acc_ff   <= acc_in;
      cost_ff  <= cost_in;
      div_ff   <= div_in;
      dmag_ff  <= dmag_in;
      util_ff  <= util_in;
      reach_ff <= reach_in;
      last_ff  <= last_in;
   end

endmodule

// ===== rtl/core/fce_mul.sv =====
module fce_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fce_pkg::MUL_W-1:0]     op_a,
   input  logic [fce_pkg::MUL_W-1:0]     op_b,
   output logic                          done,
   output logic [fce_pkg::PROD_W-1:0]    product
);
   import fce_pkg::*;

   localparam int CW = $clog2(MUL_W + 1);

   logic [MUL_W-1:0]  a_ff, a_in;
   logic [PROD_W:0]   p_ff, p_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [MUL_W:0]    upper;

   // one multiplier bit per cycle, shift-add
   always_comb begin
      upper   = p_ff[PROD_W:MUL_W] + (p_ff[0] ? {1'b0, a_ff} : '0);
      a_in    = a_ff;
      p_in    = p_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = op_a;
         p_in   = {{(MUL_W + 1){1'b0}}, op_b};
         cnt_in = CW'(MUL_W);
      end else if (cnt_ff != '0) begin
         p_in    = {1'b0, upper, p_ff[MUL_W-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      p_ff <= p_in;
   end

   assign done    = done_ff;
   assign product = p_ff[PROD_W-1:0];

endmodule

// ===== rtl/core/fce_sqrt.sv =====
module fce_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fce_pkg::SUM_W-1:0]     radicand,
   output logic                          done,
   output logic [fce_pkg::ROOT_W-1:0]    root
);
   import fce_pkg::*;

   localparam int CW = $clog2(ROOT_W + 1);

   logic [SUM_W-1:0] v_ff, v_in;
   logic [SUM_W-1:0] r_ff, r_in;
   logic [SUM_W-1:0] bit_ff, bit_in;
   logic [SUM_W-1:0] trial;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             done_ff, done_in;

   // one root bit per cycle
   always_comb begin
      trial   = r_ff + bit_ff;
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         v_in   = radicand;
         r_in   = '0;
         bit_in = SUM_W'(1) << (SUM_W - 2);
         cnt_in = CW'(ROOT_W);
      end else if (cnt_ff != '0) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[ROOT_W-1:0];

endmodule

// ===== rtl/core/fce_div.sv =====
module fce_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fce_pkg::DIV_W-1:0]     dividend,
   input  logic [fce_pkg::DIV_W-1:0]     divisor,
   output logic                          done,
   output logic [fce_pkg::DIV_W-1:0]     quotient
);
   import fce_pkg::*;

   localparam int CW = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] d_ff, d_in;
   logic [DIV_W:0]   shifted;
   logic             fits;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             done_ff, done_in;

   // restoring division, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      fits    = (shifted >= {1'b0, d_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         d_in   = divisor;
         cnt_in = CW'(DIV_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? DIV_W'(shifted - {1'b0, d_ff}) : shifted[DIV_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      d_ff   <= d_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/fce_checker.sv =====
module fce_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fce_pkg::rsp_type rsp_payload,
   input logic             pready
);
   import fce_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped under stall");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // out-of-range cluster carries saturated cost and no utility
   a_unreach: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.reachable |->
         rsp_payload.cost == COST_MAX && rsp_payload.utility == '0)
      else $error("bad unreachable result");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.reachable |-> rsp_payload.reachable_total != '0)
      else $error("reachable transfer without count");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("register port not ready");

endmodule

bind frontier_cost_evaluator fce_checker u_fce_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload),
   .pready      (pready)
);
